// ===== hw/rtl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and codes of the page frame allocator
// Request and response payloads, action codes, control states and the
// decoded work descriptor passed from the decoder to the core.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // Widest word index over the parameter range (8192 words of 64 pages)
    localparam int WORD_IDX_W = 13;

    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_FREE     = 3'd1;
    localparam logic [2:0] ACT_REGION   = 3'd2;
    localparam logic [2:0] ACT_RESERVE  = 3'd3;
    localparam logic [2:0] ACT_MARK_ALL = 3'd4;

    localparam logic [31:0] REGION_USABLE = 32'd1;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] address;
        logic [47:0] region_length;
        logic [31:0] region_type;
    } req_t;

    typedef struct packed {
        logic [47:0] page_address;
        logic        ok;
    } rsp_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ALLOC,
        KIND_SPAN,
        KIND_FILL
    } span_kind_t;

    typedef struct packed {
        span_kind_t            kind;
        logic                  set_bits;
        logic                  ok;
        logic [WORD_IDX_W-1:0] first_word;
        logic [WORD_IDX_W-1:0] last_word;
        logic [5:0]            first_bit;
        logic [5:0]            last_bit;
    } span_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DISPATCH,
        ST_WALK_ALLOC,
        ST_WALK_SPAN,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/bpfa_decode.sv =====
// ----------------------------------------------------------------------------
// bpfa_decode: request to page span decoder
// Rounds region and reserve ranges to pages, clamps them to the store and
// splits the first and last page into word index and bit position.
// ----------------------------------------------------------------------------
module bpfa_decode #(
    parameter int BITMAP_BYTES = 4096,
    parameter int PAGE_SHIFT   = 12
) (
    input  bpfa_pkg::req_t  req,
    output bpfa_pkg::span_t span
);

    localparam int SUM_W     = 50;
    localparam int PG_W      = SUM_W - PAGE_SHIFT;
    localparam int NUM_PAGES = BITMAP_BYTES * 8;

    localparam logic [SUM_W-1:0] PAGE_M1 = SUM_W'((1 << PAGE_SHIFT) - 1);
    localparam logic [PG_W-1:0]  NP_PG   = PG_W'(NUM_PAGES);
    localparam logic [PG_W-1:0]  NP_LAST = PG_W'(NUM_PAGES - 1);

    logic [SUM_W-1:0] addr_x;
    logic [SUM_W-1:0] len_x;
    logic [SUM_W-1:0] start_up;
    logic [SUM_W-1:0] end_raw;
    logic [SUM_W-1:0] end_up;
    logic [PG_W-1:0]  first_pg;
    logic [PG_W-1:0]  stop_pg;
    logic [PG_W-1:0]  last_pg;
    logic [PG_W-1:0]  free_pg;
    logic             empty;
    logic             free_ok;

    always_comb
    begin
        addr_x   = SUM_W'(req.address);
        len_x    = SUM_W'(req.region_length);
        start_up = addr_x + PAGE_M1;
        end_raw  = addr_x + len_x;
        end_up   = end_raw + PAGE_M1;

        // Reserve rounds outward, an available region rounds inward
        if (req.action == bpfa_pkg::ACT_RESERVE)
        begin
            first_pg = addr_x[SUM_W-1:PAGE_SHIFT];
            stop_pg  = end_up[SUM_W-1:PAGE_SHIFT];
        end
        else
        begin
            first_pg = start_up[SUM_W-1:PAGE_SHIFT];
            stop_pg  = end_raw[SUM_W-1:PAGE_SHIFT];
        end

        last_pg = (stop_pg > NP_PG) ? NP_LAST : (stop_pg - PG_W'(1));
        empty   = (first_pg >= stop_pg) || (first_pg >= NP_PG);

        free_pg = addr_x[SUM_W-1:PAGE_SHIFT];
        free_ok = free_pg < NP_PG;

        span.kind       = bpfa_pkg::KIND_NONE;
        span.set_bits   = 1'b0;
        span.ok         = 1'b0;
        span.first_word = first_pg[6 +: bpfa_pkg::WORD_IDX_W];
        span.last_word  = last_pg[6 +: bpfa_pkg::WORD_IDX_W];
        span.first_bit  = first_pg[5:0];
        span.last_bit   = last_pg[5:0];

        case (req.action)
            bpfa_pkg::ACT_ALLOC:
            begin
                span.kind = bpfa_pkg::KIND_ALLOC;
            end
            bpfa_pkg::ACT_FREE:
            begin
                span.first_word = free_pg[6 +: bpfa_pkg::WORD_IDX_W];
                span.last_word  = free_pg[6 +: bpfa_pkg::WORD_IDX_W];
                span.first_bit  = free_pg[5:0];
                span.last_bit   = free_pg[5:0];
                span.ok         = free_ok;
                span.kind       = free_ok ? bpfa_pkg::KIND_SPAN : bpfa_pkg::KIND_NONE;
            end
            bpfa_pkg::ACT_REGION:
            begin
                if (req.region_type == bpfa_pkg::REGION_USABLE)
                begin
                    span.ok   = 1'b1;
                    span.kind = empty ? bpfa_pkg::KIND_NONE : bpfa_pkg::KIND_SPAN;
                end
            end
            bpfa_pkg::ACT_RESERVE:
            begin
                span.ok       = 1'b1;
                span.set_bits = 1'b1;
                span.kind     = empty ? bpfa_pkg::KIND_NONE : bpfa_pkg::KIND_SPAN;
            end
            bpfa_pkg::ACT_MARK_ALL:
            begin
                span.ok   = 1'b1;
                span.kind = bpfa_pkg::KIND_FILL;
            end
            default:
            begin
                span.kind = bpfa_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core: first-fit physical page allocator
// One used bit per page, held in a single-port-read bitmap memory of
// 64-bit words; alloc, free, region and reserve are read-modify-write walks.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_data) is taken when req_valid is high and req_stall is low.
//   Exactly one response (rsp_data) follows per request, in order, and is
//   taken when rsp_valid is high and rsp_stall is low.
//   The block works on one request at a time; req_stall is high while a
//   request is in progress.
//   A request is decoded and dispatched; free, region and reserve then walk
//   their span of bitmap words, allocate scans from word 0 up to the first
//   word with a clear bit (or the whole store when full), mark all refills
//   the store, and empty or ignored actions answer straight from dispatch.
//   The walk runs one bitmap word per cycle, paced by the memory read port
//   (registered read data, reads pipelined against write-back).
//   Reset starts a fill pass that sets every word to all ones;
//   requests are stalled until it finishes.
//   The response sits in an output register: a stalled receiver holds it
//   there, and the block still takes and works the next request, parking
//   that result until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core #(
    parameter int BITMAP_BYTES = 4096,
    parameter int PAGE_SHIFT   = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bpfa_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bpfa_pkg::rsp_t  rsp_data
);

    localparam int NUM_WORDS = (BITMAP_BYTES + 7) / 8;
    localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic [WI_W-1:0] LAST_WORD = WI_W'(NUM_WORDS - 1);
    localparam logic [63:0]     ALL_ONES  = {64{1'b1}};

    // Lowest clear bit of a word that is known not to be all ones
    function automatic logic [5:0] first_zero(input logic [63:0] w);
        logic [63:0] v;
        logic [5:0]  idx;
        v   = ~w;
        idx = 6'd0;
        if (v[31:0] == 32'd0)
        begin
            idx[5] = 1'b1;
            v      = v >> 32;
        end
        if (v[15:0] == 16'd0)
        begin
            idx[4] = 1'b1;
            v      = v >> 16;
        end
        if (v[7:0] == 8'd0)
        begin
            idx[3] = 1'b1;
            v      = v >> 8;
        end
        if (v[3:0] == 4'd0)
        begin
            idx[2] = 1'b1;
            v      = v >> 4;
        end
        if (v[1:0] == 2'd0)
        begin
            idx[1] = 1'b1;
            v      = v >> 2;
        end
        if (v[0] == 1'b0)
        begin
            idx[0] = 1'b1;
        end
        return idx;
    endfunction

    // Control state
    bpfa_pkg::state_t state_reg, state_next;
    logic [WI_W-1:0]  ptr_reg, ptr_next;
    logic [WI_W-1:0]  end_word_reg, end_word_next;
    logic             more_reg, more_next;
    logic             pend_reg, pend_next;
    logic [WI_W-1:0]  pend_word_reg, pend_word_next;
    logic             fill_rsp_reg, fill_rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload
    bpfa_pkg::req_t   req_reg, req_next;
    bpfa_pkg::span_t  span_reg, span_next;
    bpfa_pkg::rsp_t   res_reg, res_next;
    bpfa_pkg::rsp_t   rsp_reg, rsp_next;

    bpfa_pkg::span_t  dec_span;

    // Bitmap memory
    logic [63:0]      bitmap_mem [NUM_WORDS];
    logic [63:0]      rdata_reg;
    logic             mem_re;
    logic             mem_we;
    logic [WI_W-1:0]  mem_waddr;
    logic [63:0]      mem_wdata;

    // Work on the word whose read data has just returned
    logic [5:0]       lo_bit;
    logic [5:0]       hi_bit;
    logic [63:0]      span_mask;
    logic [5:0]       free_bit;

    bpfa_decode #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) u_decode (
        .req  (req_reg),
        .span (dec_span)
    );

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= bitmap_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfa_pkg::ST_CLEAR;
            ptr_reg       <= '0;
            end_word_reg  <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_word_reg <= '0;
            fill_rsp_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            end_word_reg  <= end_word_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            pend_word_reg <= pend_word_next;
            fill_rsp_reg  <= fill_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        span_reg <= span_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    // Bit range of the span that falls into the returned word
    always_comb
    begin
        lo_bit    = (pend_word_reg == span_reg.first_word[WI_W-1:0]) ?
                    span_reg.first_bit : 6'd0;
        hi_bit    = (pend_word_reg == span_reg.last_word[WI_W-1:0]) ?
                    span_reg.last_bit : 6'd63;
        span_mask = (ALL_ONES << lo_bit) & (ALL_ONES >> (6'd63 - hi_bit));
        free_bit  = first_zero(rdata_reg);
    end

    assign req_stall = (state_reg != bpfa_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        end_word_next  = end_word_reg;
        more_next      = more_reg;
        pend_next      = 1'b0;
        pend_word_next = pend_word_reg;
        fill_rsp_next  = fill_rsp_reg;
        req_next       = req_reg;
        span_next      = span_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_word_reg;
        mem_wdata      = rdata_reg;

        case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                // Set one word per cycle to all used
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = ALL_ONES;
                if (ptr_reg == LAST_WORD)
                begin
                    ptr_next      = '0;
                    fill_rsp_next = 1'b0;
                    if (fill_rsp_reg)
                    begin
                        res_next   = '{page_address: 48'd0, ok: 1'b1};
                        state_next = bpfa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bpfa_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + WI_W'(1);
                end
            end

            bpfa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = bpfa_pkg::ST_DECODE;
                end
            end

            bpfa_pkg::ST_DECODE:
            begin
                span_next  = dec_span;
                state_next = bpfa_pkg::ST_DISPATCH;
            end

            bpfa_pkg::ST_DISPATCH:
            begin
                case (span_reg.kind)
                    bpfa_pkg::KIND_ALLOC:
                    begin
                        ptr_next      = '0;
                        end_word_next = LAST_WORD;
                        more_next     = 1'b1;
                        state_next    = bpfa_pkg::ST_WALK_ALLOC;
                    end
                    bpfa_pkg::KIND_SPAN:
                    begin
                        ptr_next      = span_reg.first_word[WI_W-1:0];
                        end_word_next = span_reg.last_word[WI_W-1:0];
                        more_next     = 1'b1;
                        state_next    = bpfa_pkg::ST_WALK_SPAN;
                    end
                    bpfa_pkg::KIND_FILL:
                    begin
                        ptr_next      = '0;
                        fill_rsp_next = 1'b1;
                        state_next    = bpfa_pkg::ST_CLEAR;
                    end
                    default:
                    begin
                        res_next   = '{page_address: 48'd0, ok: span_reg.ok};
                        state_next = bpfa_pkg::ST_DONE;
                    end
                endcase
            end

            bpfa_pkg::ST_WALK_ALLOC:
            begin
                // Issue the next read while the previous word is checked
                if (more_reg)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_word_next = ptr_reg;
                    if (ptr_reg == end_word_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + WI_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (rdata_reg != ALL_ONES)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = rdata_reg | (64'd1 << free_bit);
                        res_next   = '{page_address: 48'({pend_word_reg, free_bit}) << PAGE_SHIFT,
                                       ok: 1'b1};
                        more_next  = 1'b0;
                        pend_next  = 1'b0;
                        state_next = bpfa_pkg::ST_DONE;
                    end
                    else if (!more_reg)
                    begin
                        res_next   = '{page_address: 48'd0, ok: 1'b0};
                        pend_next  = 1'b0;
                        state_next = bpfa_pkg::ST_DONE;
                    end
                end
            end

            bpfa_pkg::ST_WALK_SPAN:
            begin
                if (more_reg)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_word_next = ptr_reg;
                    if (ptr_reg == end_word_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + WI_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    // Write back the returned word with its span bits set or cleared
                    mem_we    = 1'b1;
                    mem_wdata = span_reg.set_bits ? (rdata_reg | span_mask) :
                                                    (rdata_reg & ~span_mask);
                    if (!more_reg)
                    begin
                        res_next   = '{page_address: 48'd0, ok: 1'b1};
                        pend_next  = 1'b0;
                        state_next = bpfa_pkg::ST_DONE;
                    end
                end
            end

            bpfa_pkg::ST_DONE:
            begin
                // Hold the result until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = bpfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== test/bpfa_checker.sv =====
// ----------------------------------------------------------------------------
// bpfa_checker: response checker for the page frame allocator
// Watches both channels, keeps a private copy of the page bitmap, predicts
// the answer to every accepted request and compares it with the response.
// ----------------------------------------------------------------------------
module bpfa_checker #(
    parameter int BITMAP_BYTES = 4096,
    parameter int PAGE_SHIFT   = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  bpfa_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  bpfa_pkg::rsp_t rsp_data,
    output int             errors,
    output int             backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned NUM_PAGES  = longint'(BITMAP_BYTES) * 8;
    localparam int              NUM_WORDS  = (BITMAP_BYTES + 7) / 8;
    localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT;

    logic [63:0]    used_map [NUM_WORDS];
    bpfa_pkg::rsp_t answer_q [$];

    initial errors = 0;

    function automatic void mark_all_used();
        for (int w = 0; w < NUM_WORDS; w++)
            used_map[w] = '1;
    endfunction

    // Set or clear pages first..stop-1, clipped to the store, a word at a time.
    function automatic void mark_pages(logic [63:0] first, logic [63:0] stop, logic used);
        logic [63:0] pg;
        logic [63:0] n;
        logic [63:0] mask;
        int unsigned w;
        if (stop > NUM_PAGES)
            stop = NUM_PAGES;
        pg = first;
        while (pg < stop)
        begin
            w = 32'(pg >> 6);
            n = 64'd64 - 64'(pg[5:0]);
            if (n > stop - pg)
                n = stop - pg;
            mask = (n == 64'd64) ? '1 : (((64'd1 << n) - 64'd1) << pg[5:0]);
            if (used)
                used_map[w] = used_map[w] | mask;
            else
                used_map[w] = used_map[w] & ~mask;
            pg = pg + n;
        end
    endfunction

    // Apply one request to the bitmap copy and return its answer.
    function automatic bpfa_pkg::rsp_t predict_answer(bpfa_pkg::req_t r);
        bpfa_pkg::rsp_t ans;
        logic [63:0]    a;
        logic [63:0]    len;
        logic [63:0]    pg;
        logic [63:0]    byte_addr;
        logic           hit;
        ans = '0;
        a   = 64'(r.address);
        len = 64'(r.region_length);
        hit = 1'b0;
        case (r.action)
            bpfa_pkg::ACT_ALLOC:
            begin
                for (int w = 0; w < NUM_WORDS && !hit; w++)
                begin
                    if (used_map[w] != '1)
                    begin
                        for (int b = 0; b < 64 && !hit && (64'(w) * 64 + 64'(b) < NUM_PAGES);
                             b++)
                        begin
                            if (!used_map[w][b])
                            begin
                                used_map[w][b] = 1'b1;
                                pg = 64'(w) * 64 + 64'(b);
                                byte_addr = pg << PAGE_SHIFT;
                                ans.page_address = byte_addr[47:0];
                                hit = 1'b1;
                            end
                        end
                    end
                end
                ans.ok = hit;
            end
            bpfa_pkg::ACT_FREE:
            begin
                pg = a >> PAGE_SHIFT;
                if (pg < NUM_PAGES)
                begin
                    mark_pages(pg, pg + 64'd1, 1'b0);
                    ans.ok = 1'b1;
                end
            end
            bpfa_pkg::ACT_REGION:
            begin
                // usable RAM only: round the start up, the end down
                if (r.region_type == bpfa_pkg::REGION_USABLE)
                begin
                    mark_pages((a + PAGE_BYTES - 1) >> PAGE_SHIFT, (a + len) >> PAGE_SHIFT, 1'b0);
                    ans.ok = 1'b1;
                end
            end
            bpfa_pkg::ACT_RESERVE:
            begin
                // round the start down, the end up
                mark_pages(a >> PAGE_SHIFT, (a + len + PAGE_BYTES - 1) >> PAGE_SHIFT, 1'b1);
                ans.ok = 1'b1;
            end
            bpfa_pkg::ACT_MARK_ALL:
            begin
                mark_all_used();
                ans.ok = 1'b1;
            end
            default:
                ans.ok = 1'b0;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        bpfa_pkg::rsp_t want;
        if (!rst_n)
        begin
            mark_all_used();
            answer_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: response without a request, expected none, actual %h/%b",
                             $time, rsp_data.page_address, rsp_data.ok);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_data.page_address !== want.page_address)
                    begin
                        errors++;
                        $display("%0t: page_address mismatch, expected %h, actual %h",
                                 $time, want.page_address, rsp_data.page_address);
                    end
                    if (rsp_data.ok !== want.ok)
                    begin
                        errors++;
                        $display("%0t: ok mismatch, expected %b, actual %b",
                                 $time, want.ok, rsp_data.ok);
                    end
                end
            end
            if (req_valid && !req_stall)
                answer_q.push_back(predict_answer(req_data));
        end
        backlog = answer_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the bitmap page frame allocator
// Drives directed and random request streams with bursty sending and a
// stalling receiver; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BITMAP_BYTES = 4096;
    localparam int PAGE_SHIFT   = 12;
    localparam int NUM_PAGES    = BITMAP_BYTES * 8;
    localparam int NUM_WORDS    = (BITMAP_BYTES + 7) / 8;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;

    // total request count, receiver hold-off, and cycles without any
    // handshake before the run is declared hung
    localparam int TOTAL_ITEMS  = 1170;
    localparam int HOLD_CYCLES  = 1500;
    localparam int QUIET_LIMIT  = 10000;

    // action codes the block leaves unused
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_PERIOD = 2;

    localparam logic [47:0] ADDR_MAX = '1;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    bpfa_pkg::req_t req_data  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    bpfa_pkg::rsp_t rsp_data;

    int errors;
    int backlog;

    // requests accepted by the block and responses taken from it
    int req_sent = 0;
    int rsp_seen = 0;

    // requests left in the current sender burst
    int burst_left = 1;

    // raised once by the stimulus to have the receiver hold off
    bit hold_off_wanted = 1'b0;

    // page window the well-formed traffic of a phase works in
    int win_base  = 0;
    int win_pages = 1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bitmap_page_frame_allocator_core #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    bpfa_checker #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .errors    (errors),
        .backlog   (backlog)
    );

    // Count responses as they are taken; the sender drains against this.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            rsp_seen <= rsp_seen + 1;
    end

    function automatic logic [47:0] random_bits48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic logic [47:0] page_to_addr(logic [63:0] pg);
        logic [63:0] a;
        a = pg << PAGE_SHIFT;
        return a[47:0];
    endfunction

    function automatic bpfa_pkg::req_t make_req(logic [2:0] act, logic [47:0] addr,
                                                logic [47:0] len, logic [31:0] rtype);
        bpfa_pkg::req_t r;
        r.action        = act;
        r.address       = addr;
        r.region_length = len;
        r.region_type   = rtype;
        return r;
    endfunction

    // Hand the whole window back as usable RAM.
    function automatic bpfa_pkg::req_t window_region();
        return make_req(bpfa_pkg::ACT_REGION, page_to_addr(win_base),
                        page_to_addr(win_pages), bpfa_pkg::REGION_USABLE);
    endfunction

    // Mostly allocate/free traffic inside the window, with some region and
    // reserve edits, and a tail of noise: wild addresses, huge spans, spare
    // action codes, and the occasional mark-all.
    function automatic bpfa_pkg::req_t random_request();
        int unsigned pick;
        logic [63:0] pg;
        logic [47:0] off;
        pick = $urandom_range(0, 99);
        pg   = $urandom_range(win_base, win_base + win_pages - 1);
        off  = 48'($urandom_range(0, PAGE_BYTES - 1));
        if (pick < 40)
            return make_req(bpfa_pkg::ACT_ALLOC, random_bits48(), random_bits48(), $urandom());
        else if (pick < 70)
            return make_req(bpfa_pkg::ACT_FREE, page_to_addr(pg) | off, random_bits48(),
                            $urandom());
        else if (pick < 78)
            return make_req(bpfa_pkg::ACT_REGION, page_to_addr(pg) | off,
                            48'($urandom_range(0, 8 * PAGE_BYTES)), bpfa_pkg::REGION_USABLE);
        else if (pick < 85)
            return make_req(bpfa_pkg::ACT_RESERVE, page_to_addr(pg) | off,
                            48'($urandom_range(0, 4 * PAGE_BYTES)), $urandom());
        else if (pick < 90)
            return make_req(bpfa_pkg::ACT_REGION, page_to_addr(pg) | off,
                            48'($urandom_range(0, 8 * PAGE_BYTES)),
                            ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom());
        else if (pick < 93)
            return make_req(bpfa_pkg::ACT_FREE, random_bits48(), random_bits48(), $urandom());
        else if (pick < 95)
            return make_req(($urandom_range(0, 1) == 0) ? bpfa_pkg::ACT_REGION :
                                                          bpfa_pkg::ACT_RESERVE,
                            random_bits48(), random_bits48(), bpfa_pkg::REGION_USABLE);
        else if (pick < 98)
            return make_req(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                            random_bits48(), random_bits48(), $urandom());
        else
            return make_req(bpfa_pkg::ACT_MARK_ALL, random_bits48(), random_bits48(),
                            $urandom());
    endfunction

    // Offer one request and hold it until the block takes it. Keep valid up
    // inside a burst; at the end of a burst drop it for a random gap.
    task automatic issue_request(input bpfa_pkg::req_t r);
        int gap;
        req_data  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        req_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every accepted request has its response.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (rsp_seen < req_sent);
    endtask

    // Receiver: switch between stall patterns in segments of random length.
    // Once the stimulus asks, hold off for a long stretch so the block fills
    // up and stalls its request side.
    initial
    begin : receiver
        int  seg;
        int  mode;
        int  tick;
        bit  held;
        held = 1'b0;
        tick = 0;
        forever
        begin
            seg  = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (seg)
            begin
                @(posedge clk);
                if (hold_off_wanted && !held)
                begin
                    held = 1'b1;
                    rsp_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                tick++;
                case (mode)
                    STALL_NONE:   rsp_stall <= 1'b0;
                    STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIOD: rsp_stall <= ((tick % 5) < 2);
                    default:      rsp_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int             phase;
        int             phase_len;
        bpfa_pkg::req_t r;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // everything is used after reset: allocate must fail
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_FREE, page_to_addr(0), '0, '0));
        // frees past the store are refused
        issue_request(make_req(bpfa_pkg::ACT_FREE, page_to_addr(NUM_PAGES), '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_FREE, ADDR_MAX, ADDR_MAX, '1));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        // unaligned usable region: start rounds up, end rounds down
        issue_request(make_req(bpfa_pkg::ACT_REGION, 48'h1001, 48'h3000,
                               bpfa_pkg::REGION_USABLE));
        // region types other than usable RAM are ignored
        issue_request(make_req(bpfa_pkg::ACT_REGION, 48'h0, 48'h10000, '1));
        issue_request(make_req(bpfa_pkg::ACT_REGION, 48'h0, 48'h10000, 32'd0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, ADDR_MAX, ADDR_MAX, '1));
        // zero-length reserve at an unaligned address still takes a page
        issue_request(make_req(bpfa_pkg::ACT_REGION, 48'h0, 48'h10000,
                               bpfa_pkg::REGION_USABLE));
        issue_request(make_req(bpfa_pkg::ACT_RESERVE, 48'h2800, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        // full-range region and reserve; spans past the store are clipped
        issue_request(make_req(bpfa_pkg::ACT_REGION, '0, ADDR_MAX, bpfa_pkg::REGION_USABLE));
        issue_request(make_req(bpfa_pkg::ACT_RESERVE, ADDR_MAX, ADDR_MAX, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_RESERVE, '0, ADDR_MAX, '0));
        // only the last page comes back; allocate walks the whole store
        issue_request(make_req(bpfa_pkg::ACT_REGION, page_to_addr(NUM_PAGES - 1),
                               page_to_addr(16), bpfa_pkg::REGION_USABLE));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_FREE, page_to_addr(NUM_PAGES - 1) | 48'hFFF,
                               '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_MARK_ALL, '0, '0, '0));
        issue_request(make_req(bpfa_pkg::ACT_ALLOC, '0, '0, '0));
        issue_request(make_req(ACT_SPARE_LAST, ADDR_MAX, ADDR_MAX, '1));
        wait_for_responses();

        // ---- random part, in phases that each drain at the end ----
        phase = 0;
        while (req_sent < TOTAL_ITEMS)
        begin
            phase_len = $urandom_range(40, 120);
            if (phase_len > TOTAL_ITEMS - req_sent)
                phase_len = TOTAL_ITEMS - req_sent;
            // keep most windows low so allocation scans stay short
            if ($urandom_range(0, 7) == 0)
                win_base = $urandom_range(0, NUM_PAGES - 256);
            else
                win_base = $urandom_range(0, 255);
            win_pages = $urandom_range(1, 192);
            if ($urandom_range(0, 1) == 0)
                issue_request(make_req(bpfa_pkg::ACT_MARK_ALL, random_bits48(),
                                       random_bits48(), $urandom()));
            issue_request(window_region());
            // reserve the first page of the window, as software does page 0
            if ($urandom_range(0, 1) == 0)
                issue_request(make_req(bpfa_pkg::ACT_RESERVE, page_to_addr(win_base), '0,
                                       $urandom()));
            for (int i = 0; i < phase_len; i++)
            begin
                if (phase == 2 && i == 10)
                    hold_off_wanted = 1'b1;
                r = random_request();
                issue_request(r);
                // reopen the window after a mark-all so allocations go on
                if (r.action == bpfa_pkg::ACT_MARK_ALL)
                    issue_request(window_region());
            end
            wait_for_responses();
            phase++;
        end

        // let the block settle, then give the verdict
        repeat (NUM_WORDS + 16) @(posedge clk);
        if (errors == 0 && backlog == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
